### rtl/ats_pkg.sv
// Shared types, codes and constants for the aging task scheduler.
`default_nettype none

package ats_pkg;

    localparam int DEF_SLOTS = 16;
    localparam logic [15:0] ACCT_RESET   = 16'd100;
    localparam logic [15:0] PERIOD_RESET = 16'd1;
    localparam logic [15:0] MAX16        = 16'hFFFF;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_SLEEP   = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;

    typedef struct packed {
        logic        occupied;
        logic [1:0]  run_state;
        logic [15:0] sleep_cnt;
        logic [15:0] age;
        logic [15:0] exec_cnt;
        logic [15:0] cpu;
    } t_rec;

    typedef struct packed {
        logic win_end;
        logic idle_slot;
    } t_step_ctl;

endpackage

`default_nettype wire

### rtl/aging_task_scheduler.sv
// Top level of the aging task scheduler: slot table, walk sequencer, ports.
//
//  channel  | handshake          | direction | content
//  ---------+--------------------+-----------+------------------------------------
//  input    | i_valid / o_ready  | in        | command, stack pointer, slot fields
//  output   | o_valid / i_ready  | out       | slot id and that slot's stored values
//  config   | psel/penable/...   | in/out    | accounting_period at byte address 0
//
// A schedule tick does one table read and one write-back per slot through a single slot
// update unit, then a read-modify-write of the winner. Write, read and the unused
// command do one table read plus the result load.
// Reset clears the slot records at once via per-slot valid bits; stack pointers stay.
// A result waits in the output register while the next word is accepted; a new
// result is held back only until the waiting one is taken.
`default_nettype none

module aging_task_scheduler #(
    parameter int SLOTS = ats_pkg::DEF_SLOTS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_command,
    input  wire  [31:0] i_stack_ptr,
    input  wire  [3:0]  i_slot_sel,
    input  wire         i_occupied_in,
    input  wire  [1:0]  i_run_state_in,
    input  wire  [15:0] i_sleep_ticks,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [3:0]  o_slot_id,
    output logic [31:0] o_slot_stack_ptr,
    output logic        o_occupied_out,
    output logic [1:0]  o_run_state_out,
    output logic [15:0] o_sleep_left,
    output logic [15:0] o_cpu_share,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int CW = IW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_FIN_RD = 3'd2;
    localparam logic [2:0] S_FIN_WR = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;
    localparam logic [2:0] S_RPT    = 3'd5;
    localparam logic [2:0] S_LOAD   = 3'd6;

    logic [2:0]       r_state;
    logic [CW-1:0]    r_idx;
    logic [IW-1:0]    r_win;
    logic [15:0]      r_best;
    logic             r_win_end;
    logic [IW-1:0]    r_cur;
    logic [15:0]      r_period;
    logic [15:0]      r_acct;
    logic [SLOTS-1:0] r_valid;
    logic [IW-1:0]    r_tgt;
    logic             r_tgt_ok;
    logic [3:0]       r_tgt_id;
    logic             r_out_valid;

    ats_pkg::t_rec    r_rec_mem [SLOTS];
    logic [31:0]      r_sp_mem  [SLOTS];
    ats_pkg::t_rec    r_rec_q;
    logic             r_vld_q;
    logic [31:0]      r_sp_q;

    logic [3:0]       r_res_id;
    logic [31:0]      r_res_sp;
    logic             r_res_occ;
    logic [1:0]       r_res_run;
    logic [15:0]      r_res_sleep;
    logic [15:0]      r_res_cpu;

    logic [3:0]       r_o_id;
    logic [31:0]      r_o_sp;
    logic             r_o_occ;
    logic [1:0]       r_o_run;
    logic [15:0]      r_o_sleep;
    logic [15:0]      r_o_cpu;

    logic               accept;
    logic               sel_ok;
    logic               walk_last;
    logic [IW-1:0]      pidx;
    logic [IW-1:0]      rd_addr;
    ats_pkg::t_rec      rec_rd;
    ats_pkg::t_rec      alu_rec;
    logic               alu_take;
    ats_pkg::t_step_ctl alu_ctl;
    ats_pkg::t_rec      win_rec;
    ats_pkg::t_rec      wr_rec;
    logic               rec_we;
    logic [IW-1:0]      rec_waddr;
    ats_pkg::t_rec      rec_wdata;
    logic               sp_we;
    logic [IW-1:0]      sp_waddr;
    logic               load_out;
    logic               cfg_wr;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign sel_ok    = (32'(i_slot_sel) < 32'(SLOTS));
    assign walk_last = (r_idx == CW'(SLOTS));
    assign pidx      = IW'(r_idx - CW'(1));
    assign rec_rd    = r_vld_q ? r_rec_q : '0;
    assign load_out  = (r_state == S_LOAD) && (!r_out_valid || i_ready);

    assign alu_ctl.win_end   = r_win_end;
    assign alu_ctl.idle_slot = (pidx == '0);

    ats_slot_alu u_alu (
        .i_rec  (rec_rd),
        .i_ctl  (alu_ctl),
        .i_best (r_best),
        .o_rec  (alu_rec),
        .o_take (alu_take)
    );

    always_comb begin
        win_rec     = rec_rd;
        win_rec.age = 16'd0;
        if (rec_rd.exec_cnt != ats_pkg::MAX16) begin
            win_rec.exec_cnt = rec_rd.exec_cnt + 16'd1;
        end
    end

    always_comb begin
        wr_rec           = '0;
        wr_rec.occupied  = i_occupied_in;
        wr_rec.run_state = (i_run_state_in > ats_pkg::ST_BLOCKED) ? ats_pkg::ST_BLOCKED
                                                                   : i_run_state_in;
        wr_rec.sleep_cnt = i_sleep_ticks;
    end

    always_comb begin
        unique case (r_state)
            S_WALK:   rd_addr = walk_last ? '0 : IW'(r_idx);
            S_FIN_RD: rd_addr = r_win;
            default:  rd_addr = r_tgt;
        endcase
    end

    always_comb begin
        rec_we    = 1'b0;
        rec_waddr = IW'(i_slot_sel);
        rec_wdata = wr_rec;
        sp_we     = 1'b0;
        sp_waddr  = IW'(i_slot_sel);
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_command == ats_pkg::CMD_WRITE && sel_ok) begin
                    rec_we = 1'b1;
                    sp_we  = 1'b1;
                end else if (accept && i_command == ats_pkg::CMD_TICK) begin
                    sp_we    = 1'b1;
                    sp_waddr = r_cur;
                end
            end
            S_WALK: begin
                if (r_idx != '0) begin
                    rec_we    = 1'b1;
                    rec_waddr = pidx;
                    rec_wdata = alu_rec;
                end
            end
            S_FIN_WR: begin
                rec_we    = 1'b1;
                rec_waddr = r_win;
                rec_wdata = win_rec;
            end
            default: begin
                rec_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_rec_mem[rec_waddr] <= rec_wdata;
        end
        if (sp_we) begin
            r_sp_mem[sp_waddr] <= i_stack_ptr;
        end
        r_rec_q <= r_rec_mem[rd_addr];
        r_sp_q  <= r_sp_mem[rd_addr];
    end

    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_acct};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_vld_q     <= 1'b0;
            r_cur       <= '0;
            r_period    <= ats_pkg::PERIOD_RESET;
            r_acct      <= ats_pkg::ACCT_RESET;
        end else begin
            if (cfg_wr) begin
                r_acct <= pwdata[15:0];
            end
            if (rec_we) begin
                r_valid[rec_waddr] <= 1'b1;
            end
            r_vld_q <= r_valid[rd_addr];
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_command == ats_pkg::CMD_TICK) begin
                            r_state  <= S_WALK;
                            r_period <= (r_period >= r_acct) ? ats_pkg::PERIOD_RESET
                                                             : r_period + 16'd1;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_WALK: begin
                    if (walk_last) begin
                        r_state <= S_FIN_RD;
                    end
                end
                S_FIN_RD: r_state <= S_FIN_WR;
                S_FIN_WR: begin
                    r_cur   <= r_win;
                    r_state <= S_LOAD;
                end
                S_RD:     r_state <= S_RPT;
                S_RPT:    r_state <= S_LOAD;
                S_LOAD: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_idx     <= '0;
                    r_win     <= '0;
                    r_best    <= 16'd0;
                    r_win_end <= (r_period >= r_acct);
                    unique case (i_command) inside
                        ats_pkg::CMD_WRITE, ats_pkg::CMD_READ: begin
                            r_tgt    <= IW'(i_slot_sel);
                            r_tgt_ok <= sel_ok;
                            r_tgt_id <= i_slot_sel;
                        end
                        default: begin
                            r_tgt    <= r_cur;
                            r_tgt_ok <= 1'b1;
                            r_tgt_id <= 4'(r_cur);
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_idx != '0 && alu_take) begin
                    r_win  <= pidx;
                    r_best <= rec_rd.age;
                end
                if (!walk_last) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            S_FIN_WR: begin
                r_res_id    <= 4'(r_win);
                r_res_sp    <= r_sp_q;
                r_res_occ   <= win_rec.occupied;
                r_res_run   <= win_rec.run_state;
                r_res_sleep <= win_rec.sleep_cnt;
                r_res_cpu   <= win_rec.cpu;
            end
            S_RPT: begin
                r_res_id    <= r_tgt_id;
                r_res_sp    <= r_tgt_ok ? r_sp_q : 32'd0;
                r_res_occ   <= r_tgt_ok && rec_rd.occupied;
                r_res_run   <= r_tgt_ok ? rec_rd.run_state : ats_pkg::ST_READY;
                r_res_sleep <= r_tgt_ok ? rec_rd.sleep_cnt : 16'd0;
                r_res_cpu   <= r_tgt_ok ? rec_rd.cpu : 16'd0;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
        if (load_out) begin
            r_o_id    <= r_res_id;
            r_o_sp    <= r_res_sp;
            r_o_occ   <= r_res_occ;
            r_o_run   <= r_res_run;
            r_o_sleep <= r_res_sleep;
            r_o_cpu   <= r_res_cpu;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_slot_id        = r_o_id;
    assign o_slot_stack_ptr = r_o_sp;
    assign o_occupied_out   = r_o_occ;
    assign o_run_state_out  = r_o_run;
    assign o_sleep_left     = r_o_sleep;
    assign o_cpu_share      = r_o_cpu;

endmodule

`default_nettype wire

### rtl/ats_slot_alu.sv
// Per-slot update of one walk step: aging, sleep countdown, window close, oldest compare.
`default_nettype none

module ats_slot_alu (
    input  wire ats_pkg::t_rec      i_rec,
    input  wire ats_pkg::t_step_ctl i_ctl,
    input  wire [15:0]              i_best,
    output ats_pkg::t_rec           o_rec,
    output logic                    o_take
);

    always_comb begin
        o_rec  = i_rec;
        o_take = 1'b0;
        if (!i_ctl.idle_slot && i_rec.occupied && i_rec.run_state == ats_pkg::ST_READY) begin
            o_take = (i_rec.age >= i_best);
            if (i_rec.age != ats_pkg::MAX16) begin
                o_rec.age = i_rec.age + 16'd1;
            end
        end else if (!i_ctl.idle_slot && i_rec.occupied
                     && i_rec.run_state == ats_pkg::ST_SLEEP) begin
            if (i_rec.sleep_cnt <= 16'd1) begin
                o_rec.sleep_cnt = 16'd0;
                o_rec.run_state = ats_pkg::ST_READY;
            end else begin
                o_rec.sleep_cnt = i_rec.sleep_cnt - 16'd1;
            end
        end
        if (i_ctl.win_end) begin
            o_rec.cpu      = i_rec.exec_cnt;
            o_rec.exec_cnt = 16'd0;
        end
    end

endmodule

`default_nettype wire

### rtl/ats_checker.sv
// Port-level checks for the aging task scheduler and their bind to the top level.
`default_nettype none

module ats_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_ready,
    input wire [1:0]  i_command,
    input wire        o_valid,
    input wire        i_ready,
    input wire [3:0]  o_slot_id,
    input wire [31:0] o_slot_stack_ptr,
    input wire [1:0]  o_run_state_out
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted again right after a word");

    a_tick_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_command == ats_pkg::CMD_TICK)
        |=> !o_ready ##1 !o_ready ##1 !o_ready)
        else $error("schedule tick finished before walking the slots");

    a_run_state_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_run_state_out <= ats_pkg::ST_BLOCKED))
        else $error("result word carries an unused run state");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_slot_id)
                                   && $stable(o_slot_stack_ptr)))
        else $error("stalled result word changed");

endmodule

bind aging_task_scheduler ats_checker u_ats_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .i_command        (i_command),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_slot_id        (o_slot_id),
    .o_slot_stack_ptr (o_slot_stack_ptr),
    .o_run_state_out  (o_run_state_out)
);

`default_nettype wire

### tb/sched_check.sv
// Scheduler checker: models the slot table and compares every result word against it.
module sched_check (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [1:0]  i_command,
    input  wire  [31:0] i_stack_ptr,
    input  wire  [3:0]  i_slot_sel,
    input  wire         i_occupied_in,
    input  wire  [1:0]  i_run_state_in,
    input  wire  [15:0] i_sleep_ticks,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [3:0]  i_slot_id,
    input  wire  [31:0] i_slot_stack_ptr,
    input  wire         i_occupied_out,
    input  wire  [1:0]  i_run_state_out,
    input  wire  [15:0] i_sleep_left,
    input  wire  [15:0] i_cpu_share,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SLOTS            = ats_pkg::DEF_SLOTS;
    localparam logic [2:0] ADDR_ACCT_PERIOD = 3'd0;
    localparam int         SHOWN_LIMIT      = 10;

    typedef struct packed {
        logic [3:0]  id;
        logic [31:0] sp;
        logic        occupied;
        logic [1:0]  run_state;
        logic [15:0] sleep;
        logic [15:0] cpu;
    } t_slot_report;

    logic [15:0] acct_period;
    logic [15:0] window_pos;
    logic [3:0]  run_slot;
    logic        occ_tab   [SLOTS];
    logic [1:0]  state_tab [SLOTS];
    logic [15:0] sleep_tab [SLOTS];
    logic [15:0] age_tab   [SLOTS];
    logic [15:0] exec_tab  [SLOTS];
    logic [15:0] cpu_tab   [SLOTS];
    logic [31:0] sp_tab    [SLOTS];

    t_slot_report pending_reports [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void clear_table();
        int i;
        acct_period = ats_pkg::ACCT_RESET;
        window_pos  = ats_pkg::PERIOD_RESET;
        run_slot    = '0;
        for (i = 0; i < SLOTS; i++) begin
            occ_tab[i]   = 1'b0;
            state_tab[i] = ats_pkg::ST_READY;
            sleep_tab[i] = '0;
            age_tab[i]   = '0;
            exec_tab[i]  = '0;
            cpu_tab[i]   = '0;
            sp_tab[i]    = '0;
        end
    endfunction

    function automatic t_slot_report describe_slot(logic [3:0] s);
        t_slot_report r;
        r.id        = s;
        r.sp        = sp_tab[s];
        r.occupied  = occ_tab[s];
        r.run_state = state_tab[s];
        r.sleep     = sleep_tab[s];
        r.cpu       = cpu_tab[s];
        return r;
    endfunction

    function automatic logic [3:0] pick_next_task(logic [31:0] sp);
        int          i;
        logic [3:0]  winner;
        logic [15:0] best;
        logic        close_window;
        winner       = '0;
        best         = '0;
        close_window = (window_pos >= acct_period);
        sp_tab[run_slot] = sp;
        for (i = 1; i < SLOTS; i++) begin
            if (occ_tab[i] && state_tab[i] == ats_pkg::ST_READY) begin
                if (age_tab[i] >= best) begin
                    winner = 4'(i);
                    best   = age_tab[i];
                end
                if (age_tab[i] != ats_pkg::MAX16)
                    age_tab[i] = age_tab[i] + 16'd1;
            end else if (occ_tab[i] && state_tab[i] == ats_pkg::ST_SLEEP) begin
                if (sleep_tab[i] <= 16'd1) begin
                    sleep_tab[i] = '0;
                    state_tab[i] = ats_pkg::ST_READY;
                end else begin
                    sleep_tab[i] = sleep_tab[i] - 16'd1;
                end
            end
        end
        if (close_window) begin
            for (i = 0; i < SLOTS; i++) begin
                cpu_tab[i]  = exec_tab[i];
                exec_tab[i] = '0;
            end
            window_pos = ats_pkg::PERIOD_RESET;
        end else begin
            window_pos = window_pos + 16'd1;
        end
        if (exec_tab[winner] != ats_pkg::MAX16)
            exec_tab[winner] = exec_tab[winner] + 16'd1;
        age_tab[winner] = '0;
        run_slot = winner;
        return winner;
    endfunction

    function automatic t_slot_report slot_result(logic [1:0] cmd, logic [31:0] sp,
                                                 logic [3:0] sel, logic occ,
                                                 logic [1:0] rs, logic [15:0] slp);
        case (cmd)
            ats_pkg::CMD_TICK: begin
                return describe_slot(pick_next_task(sp));
            end
            ats_pkg::CMD_WRITE: begin
                occ_tab[sel]   = occ;
                state_tab[sel] = (rs > ats_pkg::ST_BLOCKED) ? ats_pkg::ST_BLOCKED : rs;
                sleep_tab[sel] = slp;
                sp_tab[sel]    = sp;
                age_tab[sel]   = '0;
                exec_tab[sel]  = '0;
                cpu_tab[sel]   = '0;
                return describe_slot(sel);
            end
            ats_pkg::CMD_READ: begin
                return describe_slot(sel);
            end
            default: begin
                return describe_slot(run_slot);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_slot_report got;
        t_slot_report want;
        if (!i_rst_n) begin
            clear_table();
            pending_reports.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_slot_id, i_slot_stack_ptr, i_occupied_out, i_run_state_out,
                        i_sleep_left, i_cpu_share};
                if (pending_reports.size() == 0) begin
                    if (o_fail_count < SHOWN_LIMIT)
                        $display("%0t: result word with none pending: slot %0d sp %h",
                                 $realtime, got.id, got.sp);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = pending_reports.pop_front();
                    if (got != want) begin
                        if (o_fail_count < SHOWN_LIMIT)
                            $display({"%0t: mismatch: expected slot %0d sp %h occ %0d st %0d ",
                                      "sleep %0d cpu %0d, got slot %0d sp %h occ %0d st %0d ",
                                      "sleep %0d cpu %0d"}, $realtime,
                                     want.id, want.sp, want.occupied, want.run_state,
                                     want.sleep, want.cpu, got.id, got.sp, got.occupied,
                                     got.run_state, got.sleep, got.cpu);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_ACCT_PERIOD)
                acct_period = pwdata[15:0];
            if (i_in_valid && i_in_ready)
                pending_reports.push_back(slot_result(i_command, i_stack_ptr, i_slot_sel,
                                                      i_occupied_in, i_run_state_in,
                                                      i_sleep_ticks));
        end
        o_pending = pending_reports.size();
    end

endmodule

### tb/tb.sv
// Testbench top for the aging task scheduler: clock, reset, stimulus, stalls and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         ITEMS_PER_PHASE  = 222;
    localparam int         PHASES           = 6;
    localparam int         CYCLE_LIMIT      = 600000;
    localparam int         HOLD_CYCLES      = 400;
    localparam int         DRAIN_CYCLES     = 30;
    localparam logic [2:0] ADDR_ACCT_PERIOD = 3'd0;
    localparam logic [1:0] CMD_CURRENT      = 2'd3;
    localparam logic [1:0] ST_UNUSED        = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] stack_ptr;
        logic [3:0]  slot_sel;
        logic        occupied;
        logic [1:0]  run_state;
        logic [15:0] sleep_ticks;
    } t_sched_word;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        i_ready        = 1'b0;
    logic [1:0]  i_command      = '0;
    logic [31:0] i_stack_ptr    = '0;
    logic [3:0]  i_slot_sel     = '0;
    logic        i_occupied_in  = 1'b0;
    logic [1:0]  i_run_state_in = '0;
    logic [15:0] i_sleep_ticks  = '0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;

    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_slot_id;
    logic [31:0] o_slot_stack_ptr;
    logic        o_occupied_out;
    logic [1:0]  o_run_state_out;
    logic [15:0] o_sleep_left;
    logic [15:0] o_cpu_share;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          n_sent     = 0;
    int          n_recv     = 0;
    int          n_tick     = 0;
    int          n_write    = 0;
    int          n_read     = 0;
    int          n_current  = 0;
    int          n_periods  = 0;
    int          cycles     = 0;
    int          burst_left = 0;
    int          hold_asks  = 0;
    int          hold_taken = 0;
    int          hold_left  = 0;
    logic [3:0]  pat_pos    = '0;
    logic [15:0] stall_pat  = 16'hFFFF;
    logic [15:0] sp_known   = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    aging_task_scheduler DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_stack_ptr      (i_stack_ptr),
        .i_slot_sel       (i_slot_sel),
        .i_occupied_in    (i_occupied_in),
        .i_run_state_in   (i_run_state_in),
        .i_sleep_ticks    (i_sleep_ticks),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_slot_id        (o_slot_id),
        .o_slot_stack_ptr (o_slot_stack_ptr),
        .o_occupied_out   (o_occupied_out),
        .o_run_state_out  (o_run_state_out),
        .o_sleep_left     (o_sleep_left),
        .o_cpu_share      (o_cpu_share),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    sched_check u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_command        (i_command),
        .i_stack_ptr      (i_stack_ptr),
        .i_slot_sel       (i_slot_sel),
        .i_occupied_in    (i_occupied_in),
        .i_run_state_in   (i_run_state_in),
        .i_sleep_ticks    (i_sleep_ticks),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_slot_id        (o_slot_id),
        .i_slot_stack_ptr (o_slot_stack_ptr),
        .i_occupied_out   (o_occupied_out),
        .i_run_state_out  (o_run_state_out),
        .i_sleep_left     (o_sleep_left),
        .i_cpu_share      (o_cpu_share),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (o_valid && i_ready)
            n_recv <= n_recv + 1;
    end

    // hold off for a long stretch on request, else stall on a rotating pattern
    always @(negedge i_clk) begin
        logic [15:0] fresh;
        if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            if (pat_pos == 4'd0) begin
                fresh     = $urandom;
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (fresh | 16'h0001);
            end
            i_ready <= stall_pat[pat_pos];
            pat_pos = pat_pos + 4'd1;
        end
    end

    task automatic send_word(input t_sched_word w);
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_command      <= w.command;
        i_stack_ptr    <= w.stack_ptr;
        i_slot_sel     <= w.slot_sel;
        i_occupied_in  <= w.occupied;
        i_run_state_in <= w.run_state;
        i_sleep_ticks  <= w.sleep_ticks;
        do @(posedge i_clk); while (!o_ready);
        n_sent = n_sent + 1;
        case (w.command)
            ats_pkg::CMD_TICK:  n_tick = n_tick + 1;
            ats_pkg::CMD_WRITE: begin
                n_write = n_write + 1;
                sp_known[w.slot_sel] = 1'b1;
            end
            ats_pkg::CMD_READ:  n_read = n_read + 1;
            default:            n_current = n_current + 1;
        endcase
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
        end else begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (n_recv != n_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_periods = n_periods + 1;
    endtask

    function automatic t_sched_word random_word();
        t_sched_word w;
        int unsigned pick;
        int unsigned rs_pick;
        w.stack_ptr   = $urandom;
        w.slot_sel    = 4'($urandom_range(0, 15));
        w.occupied    = 1'($urandom_range(0, 1));
        w.run_state   = 2'($urandom_range(0, 3));
        w.sleep_ticks = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            w.command = ats_pkg::CMD_TICK;
        end else if (pick < 70) begin
            w.command  = ats_pkg::CMD_WRITE;
            w.occupied = ($urandom_range(0, 4) != 0);
            rs_pick    = $urandom_range(0, 19);
            if (rs_pick < 10)
                w.run_state = ats_pkg::ST_READY;
            else if (rs_pick < 16)
                w.run_state = ats_pkg::ST_SLEEP;
            else if (rs_pick < 19)
                w.run_state = ats_pkg::ST_BLOCKED;
            else
                w.run_state = ST_UNUSED;
            if ($urandom_range(0, 4) != 0)
                w.sleep_ticks = 16'($urandom_range(0, 6));
        end else if (pick < 92) begin
            w.command = ats_pkg::CMD_READ;
            // only slots with a stored stack pointer
            do w.slot_sel = 4'($urandom_range(0, 15)); while (!sp_known[w.slot_sel]);
        end else begin
            w.command = CMD_CURRENT;
        end
        return w;
    endfunction

    initial begin
        logic [15:0] periods [PHASES];
        int          ph;
        int          k;
        periods = '{16'd2, 16'd65535, 16'd3, 16'd100, 16'd0, 16'd7};
        periods[4] = 16'($urandom_range(2, 40));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(t_sched_word'{ats_pkg::CMD_WRITE, 32'h0000_0000, 4'd0, 1'b0,
                                ats_pkg::ST_READY, 16'h0000});
        send_word(t_sched_word'{ats_pkg::CMD_READ, 32'hFFFF_FFFF, 4'd0, 1'b1,
                                ST_UNUSED, 16'hFFFF});
        send_word(t_sched_word'{ats_pkg::CMD_TICK, 32'hFFFF_FFFF, 4'd15, 1'b1,
                                ST_UNUSED, 16'hFFFF});
        send_word(t_sched_word'{ats_pkg::CMD_WRITE, 32'hFFFF_FFFF, 4'd15, 1'b1,
                                ats_pkg::ST_READY, 16'hFFFF});
        send_word(t_sched_word'{ats_pkg::CMD_WRITE, 32'hA5A5_5A5A, 4'd1, 1'b1,
                                ats_pkg::ST_READY, 16'h0000});
        send_word(t_sched_word'{ats_pkg::CMD_WRITE, 32'h1234_5678, 4'd2, 1'b1,
                                ats_pkg::ST_SLEEP, 16'h0000});
        send_word(t_sched_word'{ats_pkg::CMD_WRITE, 32'h8765_4321, 4'd3, 1'b1,
                                ats_pkg::ST_SLEEP, 16'd2});
        send_word(t_sched_word'{ats_pkg::CMD_WRITE, 32'h5555_AAAA, 4'd4, 1'b1,
                                ST_UNUSED, 16'h5A5A});
        send_word(t_sched_word'{ats_pkg::CMD_WRITE, 32'h0C0D_0005, 4'd5, 1'b0,
                                ats_pkg::ST_READY, 16'd0});
        send_word(t_sched_word'{ats_pkg::CMD_WRITE, 32'h0000_0006, 4'd6, 1'b1,
                                ats_pkg::ST_SLEEP, 16'hFFFF});
        for (k = 0; k < 6; k++)
            send_word(t_sched_word'{ats_pkg::CMD_TICK, $urandom, 4'd0, 1'b0,
                                    ats_pkg::ST_READY, 16'd0});
        send_word(t_sched_word'{ats_pkg::CMD_READ, 32'h0, 4'd4, 1'b0,
                                ats_pkg::ST_READY, 16'd0});
        send_word(t_sched_word'{ats_pkg::CMD_READ, 32'h0, 4'd15, 1'b0,
                                ats_pkg::ST_READY, 16'd0});
        send_word(t_sched_word'{ats_pkg::CMD_READ, 32'h0, 4'd2, 1'b0,
                                ats_pkg::ST_READY, 16'd0});
        send_word(t_sched_word'{CMD_CURRENT, 32'h0, 4'd9, 1'b0,
                                ats_pkg::ST_READY, 16'd0});
        send_word(t_sched_word'{ats_pkg::CMD_TICK, 32'h0000_0001, 4'd0, 1'b0,
                                ats_pkg::ST_READY, 16'd0});
        send_word(t_sched_word'{ats_pkg::CMD_TICK, 32'h8000_0000, 4'd0, 1'b0,
                                ats_pkg::ST_READY, 16'd0});
        send_word(t_sched_word'{ats_pkg::CMD_WRITE, 32'h0000_0011, 4'd1, 1'b1,
                                ats_pkg::ST_READY, 16'd0});
        send_word(t_sched_word'{ats_pkg::CMD_READ, 32'h0, 4'd1, 1'b0,
                                ats_pkg::ST_READY, 16'd0});

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            apb_write(ADDR_ACCT_PERIOD, {16'd0, periods[ph]});
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ((ph == 1 || ph == 4) && k == 40)
                    hold_asks = hold_asks + 1;
                send_word(random_word());
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d words: %0d ticks, %0d slot writes, %0d reads, %0d current queries",
                 n_sent, n_tick, n_write, n_read, n_current);
        $display("Accounting period set %0d times (2 and 65535 among them), two long stalls",
                 n_periods);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
rtl/ats_pkg.sv
rtl/ats_slot_alu.sv
rtl/aging_task_scheduler.sv
rtl/ats_checker.sv
tb/sched_check.sv
tb/tb.sv
